[rtl/blh_pkg.sv]
// Shared package of the band lookup unit: state encoding, operation codes,
// compare flags and fixed constants. No dependencies.
package blh_pkg;

    localparam int BAND_INDEX_W = 8;
    localparam int VALUE_W      = 64;
    localparam int NUM_BANDS_W  = 9;
    localparam int OUT_W        = 80;

    localparam logic [VALUE_W-1:0]     NOT_FOUND_VALUE = 64'hC08F_3800_0000_0000;
    localparam logic [NUM_BANDS_W-1:0] NUM_BANDS_RESET = 9'd1;

    // operation codes carried on s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_NUM_BANDS = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_BACK,
        ST_FWD
    } state_t;

    typedef struct packed {
        logic below_lower;
        logic below_upper;
    } cmp_flags_t;

endpackage

[rtl/blh_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module blh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/blh_cmp.sv]
// Shared edge compare unit: tests the multipole against one band's edges.
// Depends on blh_pkg.
module blh_cmp #(
    parameter int EDGE_WIDTH = 24
) (
    input  logic [EDGE_WIDTH-1:0] mpole,
    input  logic [EDGE_WIDTH-1:0] lower,
    input  logic [EDGE_WIDTH-1:0] upper,
    output blh_pkg::cmp_flags_t   flags
);

    assign flags.below_lower = (mpole < lower);
    assign flags.below_upper = (mpole < upper);

endmodule

[rtl/blh_ctrl.sv]
// Search sequencer: input handshake, hint, band walk and output register.
// Depends on blh_pkg; drives blh_ram and reads blh_cmp flags.
module blh_ctrl #(
    parameter int MAX_BANDS  = 256,
    parameter int EDGE_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic [blh_pkg::BAND_INDEX_W-1:0]       band_index,
    input  logic [EDGE_WIDTH-1:0]                  multipole,
    input  logic                                   restart,
    input  logic [blh_pkg::NUM_BANDS_W-1:0]        num_bands,
    input  blh_pkg::cmp_flags_t                    flags,
    input  logic [blh_pkg::VALUE_W-1:0]            rd_value,
    output logic [EDGE_WIDTH-1:0]                  mpole,
    output logic                                   ram_we,
    output logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] ram_waddr,
    output logic                                   ram_re,
    output logic [(MAX_BANDS > 1 ? $clog2(MAX_BANDS) : 1)-1:0] ram_raddr,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   out_found,
    output logic [blh_pkg::BAND_INDEX_W-1:0]       out_band,
    output logic [blh_pkg::VALUE_W-1:0]            out_value
);

    localparam int IDX_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int CNT_W = $clog2(MAX_BANDS + 1);

    blh_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [EDGE_WIDTH-1:0]  mpole_reg, mpole_next;
    logic [IDX_W-1:0]       hint_reg, hint_next;
    logic                   hint_valid_reg, hint_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_found_reg, out_found_next;
    logic [blh_pkg::BAND_INDEX_W-1:0] out_band_reg, out_band_next;
    logic [blh_pkg::VALUE_W-1:0]      out_value_reg, out_value_next;

    logic [CNT_W-1:0]       count;
    logic [IDX_W-1:0]       hint_pick;
    logic [IDX_W-1:0]       start_idx;
    logic [IDX_W+blh_pkg::BAND_INDEX_W-1:0] bidx_ext;
    logic [IDX_W+blh_pkg::BAND_INDEX_W-1:0] idx_ext;
    logic                   out_free;
    logic                   last_band;
    logic                   do_found;
    logic                   do_miss;

    assign count = (32'(num_bands) > MAX_BANDS) ? CNT_W'(MAX_BANDS) : CNT_W'(num_bands);
    assign hint_pick = (restart || !hint_valid_reg) ? '0 : hint_reg;
    assign start_idx = (32'(hint_pick) >= 32'(count)) ? '0 : hint_pick;
    assign bidx_ext  = (IDX_W + blh_pkg::BAND_INDEX_W)'(band_index);
    assign idx_ext   = (IDX_W + blh_pkg::BAND_INDEX_W)'(idx_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign last_band = (32'(idx_reg) + 32'd1 >= 32'(count));

    assign in_ready  = (state_reg == blh_pkg::ST_IDLE);
    assign mpole     = mpole_reg;
    assign ram_waddr = bidx_ext[IDX_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_band  = out_band_reg;
    assign out_value = out_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= blh_pkg::ST_IDLE;
            hint_reg       <= '0;
            hint_valid_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hint_reg       <= hint_next;
            hint_valid_reg <= hint_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        mpole_reg     <= mpole_next;
        out_found_reg <= out_found_next;
        out_band_reg  <= out_band_next;
        out_value_reg <= out_value_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        mpole_next      = mpole_reg;
        hint_next       = hint_reg;
        hint_valid_next = hint_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_band_next   = out_band_reg;
        out_value_next  = out_value_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = start_idx;
        do_found        = 1'b0;
        do_miss         = 1'b0;

        unique case (state_reg)
            blh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == blh_pkg::OP_LOAD)
                    begin
                        ram_we = (32'(band_index) < MAX_BANDS);
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = start_idx;
                        idx_next   = start_idx;
                        mpole_next = multipole;
                        state_next = blh_pkg::ST_START;
                    end
                end
            end
            blh_pkg::ST_START:
            begin
                priority if (count == '0)
                begin
                    do_miss = 1'b1;
                end
                else if (flags.below_lower)
                begin
                    if (idx_reg == '0)
                    begin
                        do_miss = 1'b1;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg - 1'b1;
                        idx_next   = idx_reg - 1'b1;
                        state_next = blh_pkg::ST_BACK;
                    end
                end
                else if (!flags.below_upper)
                begin
                    if (last_band)
                    begin
                        do_miss = 1'b1;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = idx_reg + 1'b1;
                        idx_next   = idx_reg + 1'b1;
                        state_next = blh_pkg::ST_FWD;
                    end
                end
                else
                begin
                    do_found = 1'b1;
                end
            end
            blh_pkg::ST_BACK:
            begin
                priority if (!flags.below_lower)
                begin
                    do_found = 1'b1;
                end
                else if (idx_reg == '0)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - 1'b1;
                    idx_next  = idx_reg - 1'b1;
                end
            end
            blh_pkg::ST_FWD:
            begin
                priority if (flags.below_upper)
                begin
                    do_found = 1'b1;
                end
                else if (last_band)
                begin
                    do_miss = 1'b1;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = blh_pkg::ST_IDLE;
            end
        endcase

        // result waits in place (read data held) until the output register frees up
        if ((do_found || do_miss) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = do_found;
            out_band_next   = do_found ? idx_ext[blh_pkg::BAND_INDEX_W-1:0] : '0;
            out_value_next  = do_found ? rd_value : blh_pkg::NOT_FOUND_VALUE;
            hint_next       = do_found ? idx_reg : '0;
            hint_valid_next = do_found;
            state_next      = blh_pkg::ST_IDLE;
        end
    end

endmodule

[rtl/band_lookup_with_hint_unit.sv]
// Top level of the band lookup unit with search hint.
// Depends on blh_pkg, blh_ram, blh_cmp and blh_ctrl.
//
// Usage:
//  s_axis: one transaction per item. s_tuser is the operation (load or
//  lookup). A load writes one band's edges and value into the band table
//  and gives no result. A lookup gives exactly one result on m_axis.
//  APB: register num_bands at byte address 0; write only while idle.
// Sequencing: a load writes the table when accepted.
//  A lookup whose multipole lies in the hint band needs a table read,
//  then a compare; each band walked backward or forward adds a read and
//  compare, set by the single table read port and the one shared edge
//  comparator. s_tready is low while a lookup is in flight.
// Reset:
//  hint goes to band 0, num_bands to 1, output empty. Band table contents
//  are undefined until loaded; no clearing pass is run.
// Stall:
//  The result sits in an output register; the next item is accepted while
//  it waits. A finished lookup holds in place until that register is free.
module band_lookup_with_hint_unit #(
    parameter int MAX_BANDS  = 256,
    parameter int EDGE_WIDTH = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // {restart_hint, multipole, band_value, upper_edge, lower_edge, band_index} low to high:
    // band_index, lower_edge, upper_edge, band_value, multipole, restart_hint, zero pad
    input  logic [((73 + 3*EDGE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  logic [0:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // low to high: found, band_found, value_out, zero pad
    output logic [blh_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int IDX_W   = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int RAM_W   = 2*EDGE_WIDTH + blh_pkg::VALUE_W;
    localparam int LO_POS  = blh_pkg::BAND_INDEX_W;
    localparam int UP_POS  = LO_POS + EDGE_WIDTH;
    localparam int VAL_POS = UP_POS + EDGE_WIDTH;
    localparam int MP_POS  = VAL_POS + blh_pkg::VALUE_W;
    localparam int RS_POS  = MP_POS + EDGE_WIDTH;

    logic [blh_pkg::NUM_BANDS_W-1:0] num_bands_reg, num_bands_next;

    logic [blh_pkg::BAND_INDEX_W-1:0] band_index;
    logic [EDGE_WIDTH-1:0]            lower_edge;
    logic [EDGE_WIDTH-1:0]            upper_edge;
    logic [blh_pkg::VALUE_W-1:0]      band_value;
    logic [EDGE_WIDTH-1:0]            multipole;
    logic                             restart_hint;

    logic                ram_we;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_raddr;
    logic [RAM_W-1:0]    ram_rdata;
    logic [EDGE_WIDTH-1:0] mpole;
    blh_pkg::cmp_flags_t flags;

    logic                             found;
    logic [blh_pkg::BAND_INDEX_W-1:0] band_found;
    logic [blh_pkg::VALUE_W-1:0]      value_out;

    assign band_index   = s_axis_tdata[LO_POS-1:0];
    assign lower_edge   = s_axis_tdata[UP_POS-1:LO_POS];
    assign upper_edge   = s_axis_tdata[VAL_POS-1:UP_POS];
    assign band_value   = s_axis_tdata[MP_POS-1:VAL_POS];
    assign multipole    = s_axis_tdata[RS_POS-1:MP_POS];
    assign restart_hint = s_axis_tdata[RS_POS];

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == blh_pkg::REG_NUM_BANDS) ? 32'(num_bands_reg) : '0;

    always_comb
    begin
        num_bands_next = num_bands_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == blh_pkg::REG_NUM_BANDS))
        begin
            num_bands_next = pwdata[blh_pkg::NUM_BANDS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bands_reg <= blh_pkg::NUM_BANDS_RESET;
        end
        else
        begin
            num_bands_reg <= num_bands_next;
        end
    end

    blh_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_BANDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({band_value, upper_edge, lower_edge}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    blh_cmp #(
        .EDGE_WIDTH (EDGE_WIDTH)
    ) u_cmp (
        .mpole (mpole),
        .lower (ram_rdata[EDGE_WIDTH-1:0]),
        .upper (ram_rdata[2*EDGE_WIDTH-1:EDGE_WIDTH]),
        .flags (flags)
    );

    blh_ctrl #(
        .MAX_BANDS  (MAX_BANDS),
        .EDGE_WIDTH (EDGE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .op         (s_axis_tuser[0]),
        .band_index (band_index),
        .multipole  (multipole),
        .restart    (restart_hint),
        .num_bands  (num_bands_reg),
        .flags      (flags),
        .rd_value   (ram_rdata[RAM_W-1:2*EDGE_WIDTH]),
        .mpole      (mpole),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_found  (found),
        .out_band   (band_found),
        .out_value  (value_out)
    );

    assign m_axis_tdata = blh_pkg::OUT_W'({value_out, band_found, found});

endmodule

[rtl/blh_checker.sv]
// Port-level checker for the band lookup unit, bound to the top level.
// Depends on blh_pkg and band_lookup_with_hint_unit.
module blh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [blh_pkg::OUT_W-1:0] m_axis_tdata
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // a miss carries band 0 and the -999 pattern
    a_miss_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |->
            (m_axis_tdata[8:1] == '0) && (m_axis_tdata[72:9] == blh_pkg::NOT_FOUND_VALUE))
        else $error("miss result payload wrong");

    // an accepted lookup leaves the unit busy, with s_tready low
    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == blh_pkg::OP_LOOKUP)
            |=> !s_axis_tready)
        else $error("lookup did not hold off input");

    // a load completes in its accept cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == blh_pkg::OP_LOAD)
            |=> s_axis_tready)
        else $error("load stalled input");

endmodule

bind band_lookup_with_hint_unit blh_checker u_blh_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
